// ----- sv/key_value_pair_tokenizer_defines.svh -----
// Assertion macros shared by the key/value pair tokenizer RTL.
`ifndef KEY_VALUE_PAIR_TOKENIZER_DEFINES_SVH
`define KEY_VALUE_PAIR_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define KVPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KVPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVPT_ASSERT(lbl, prop, msg)
`define KVPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/kvpt_pkg.sv -----
// Package with the codes, constants and types of the key/value pair tokenizer.
package kvpt_pkg;

  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] PH_BEFORE_KEY   = 3'd0;
  localparam logic [2:0] PH_IN_KEY       = 3'd1;
  localparam logic [2:0] PH_AFTER_KEY    = 3'd2;
  localparam logic [2:0] PH_BEFORE_VALUE = 3'd3;
  localparam logic [2:0] PH_IN_QUOTED    = 3'd4;
  localparam logic [2:0] PH_IN_PLAIN     = 3'd5;
  localparam logic [2:0] PH_HALTED       = 3'd6;

  localparam logic [2:0] ROLE_SKIP   = 3'd0;
  localparam logic [2:0] ROLE_KEY    = 3'd1;
  localparam logic [2:0] ROLE_EQUALS = 3'd2;
  localparam logic [2:0] ROLE_VALUE  = 3'd3;
  localparam logic [2:0] ROLE_TERM   = 3'd4;
  localparam logic [2:0] ROLE_HALT   = 3'd5;

  typedef struct packed {
    logic [2:0] role;
    logic       pair_done;
    logic       pair_dropped;
    logic [2:0] phase_nxt;
    logic       quote_single_nxt;
  } step_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ----- sv/kvpt_if.sv -----
// Valid/ready channel interfaces for the tokenizer's input bytes and tagged results.
interface kvpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kvpt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] role;
  logic [7:0] byte_out;
  logic       pair_done;
  logic       pair_dropped;

  modport source (output valid, output role, output byte_out, output pair_done,
                  output pair_dropped, input ready);
  modport sink (input valid, input role, input byte_out, input pair_done,
                input pair_dropped, output ready);
endinterface

// ----- sv/kvpt_step.sv -----
// Combinational phase update and byte tagging for one input beat.
module kvpt_step (
  input  logic [2:0]         phase,
  input  logic               quote_single,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output kvpt_pkg::step_res_t res
);

  logic       sp;
  logic       eq;
  logic       dq;
  logic       sq;
  logic       close_q;
  logic       key_pending;
  logic       value_open;
  logic [2:0] role;
  logic       done;
  logic       dropped;
  logic [2:0] phase_n;
  logic       quote_n;

  assign sp      = kvpt_pkg::is_space(data_byte);
  assign eq      = (data_byte == kvpt_pkg::CH_EQUALS);
  assign dq      = (data_byte == kvpt_pkg::CH_DQUOTE);
  assign sq      = (data_byte == kvpt_pkg::CH_SQUOTE);
  assign close_q = quote_single ? sq : dq;

  always_comb begin
    role        = kvpt_pkg::ROLE_SKIP;
    done        = 1'b0;
    dropped     = 1'b0;
    key_pending = 1'b0;
    value_open  = 1'b0;
    phase_n     = phase;
    quote_n     = quote_single;
    unique case (phase)
      kvpt_pkg::PH_IN_KEY: begin
        key_pending = 1'b1;
        if (eq) begin
          role    = kvpt_pkg::ROLE_EQUALS;
          phase_n = kvpt_pkg::PH_BEFORE_VALUE;
        end else if (sp) begin
          phase_n = kvpt_pkg::PH_AFTER_KEY;
        end else begin
          role = kvpt_pkg::ROLE_KEY;
        end
      end
      kvpt_pkg::PH_AFTER_KEY: begin
        if (eq) begin
          role        = kvpt_pkg::ROLE_EQUALS;
          phase_n     = kvpt_pkg::PH_BEFORE_VALUE;
          key_pending = 1'b1;
        end else if (sp) begin
          key_pending = 1'b1;
        end else begin
          role    = kvpt_pkg::ROLE_HALT;
          phase_n = kvpt_pkg::PH_HALTED;
          dropped = 1'b1;
        end
      end
      kvpt_pkg::PH_BEFORE_VALUE: begin
        if (sp) begin
          key_pending = 1'b1;
        end else if (dq || sq) begin
          quote_n    = sq;
          phase_n    = kvpt_pkg::PH_IN_QUOTED;
          value_open = 1'b1;
        end else begin
          role       = kvpt_pkg::ROLE_VALUE;
          phase_n    = kvpt_pkg::PH_IN_PLAIN;
          value_open = 1'b1;
        end
      end
      kvpt_pkg::PH_IN_QUOTED: begin
        if (close_q) begin
          role    = kvpt_pkg::ROLE_TERM;
          done    = 1'b1;
          phase_n = kvpt_pkg::PH_BEFORE_KEY;
        end else begin
          role       = kvpt_pkg::ROLE_VALUE;
          value_open = 1'b1;
        end
      end
      kvpt_pkg::PH_IN_PLAIN: begin
        if (sp) begin
          role    = kvpt_pkg::ROLE_TERM;
          done    = 1'b1;
          phase_n = kvpt_pkg::PH_BEFORE_KEY;
        end else begin
          role       = kvpt_pkg::ROLE_VALUE;
          value_open = 1'b1;
        end
      end
      kvpt_pkg::PH_HALTED: begin
        role = kvpt_pkg::ROLE_HALT;
      end
      default: begin
        if (sp) begin
          role = kvpt_pkg::ROLE_SKIP;
        end else if (eq) begin
          role        = kvpt_pkg::ROLE_EQUALS;
          phase_n     = kvpt_pkg::PH_BEFORE_VALUE;
          key_pending = 1'b1;
        end else begin
          role        = kvpt_pkg::ROLE_KEY;
          phase_n     = kvpt_pkg::PH_IN_KEY;
          key_pending = 1'b1;
        end
      end
    endcase

    if (last_byte) begin
      if (value_open) begin
        done = 1'b1;
      end else if (key_pending) begin
        dropped = 1'b1;
      end
      phase_n = kvpt_pkg::PH_BEFORE_KEY;
      quote_n = 1'b0;
    end
  end

  assign res.role             = role;
  assign res.pair_done        = done;
  assign res.pair_dropped     = dropped;
  assign res.phase_nxt        = phase_n;
  assign res.quote_single_nxt = quote_n;

endmodule

// ----- sv/key_value_pair_tokenizer.sv -----
// Top level of the key/value pair tokenizer: input register, phase state, result register.
//
//   channel   dir   payload                                     handshake
//   in_bus    in    data_byte[7:0], last_byte                   valid/ready
//   out_bus   out   role[2:0], byte_out[7:0], pair_done,        valid/ready
//                   pair_dropped
//
// One beat per cycle while out_bus is ready; a byte passes the input then the result register.
// The throughput is set by the combinational phase update between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers and returns the phase to before-key.
// A stalled output holds its beat while the input register still takes one more byte.
`include "key_value_pair_tokenizer_defines.svh"

module key_value_pair_tokenizer (
  input logic                  clk,
  input logic                  rst_n,
  kvpt_in_if.sink              in_bus,
  kvpt_out_if.source           out_bus
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  logic [2:0]          phase_r;
  logic                quote_single_r;
  logic                out_valid_r;
  logic [2:0]          out_role_r;
  logic [7:0]          out_byte_r;
  logic                out_done_r;
  logic                out_dropped_r;
  logic                advance;
  kvpt_pkg::step_res_t step_res;

  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;

  kvpt_step u_step (
    .phase        (phase_r),
    .quote_single (quote_single_r),
    .data_byte    (in_byte_r),
    .last_byte    (in_last_r),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= kvpt_pkg::PH_BEFORE_KEY;
      quote_single_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        in_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        phase_r        <= step_res.phase_nxt;
        quote_single_r <= step_res.quote_single_nxt;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.data_byte;
      in_last_r <= in_bus.last_byte;
    end
    if (advance) begin
      out_role_r    <= step_res.role;
      out_byte_r    <= in_byte_r;
      out_done_r    <= step_res.pair_done;
      out_dropped_r <= step_res.pair_dropped;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.role         = out_role_r;
  assign out_bus.byte_out     = out_byte_r;
  assign out_bus.pair_done    = out_done_r;
  assign out_bus.pair_dropped = out_dropped_r;

  `KVPT_ASSERT(a_last_restarts, advance && in_last_r |=> phase_r == kvpt_pkg::PH_BEFORE_KEY && !quote_single_r, "phase not restarted after last byte")
  `KVPT_ASSERT(a_done_xor_drop, out_valid_r |-> !(out_done_r && out_dropped_r), "pair both completed and dropped")
  `KVPT_ASSERT(a_halt_role, advance && phase_r == kvpt_pkg::PH_HALTED |=> out_role_r == kvpt_pkg::ROLE_HALT, "halted phase gave a non-halt role")
  `KVPT_ASSERT(a_in_hold, in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r), "input register lost a stalled beat")

endmodule

// ----- tb/sv/tb_key_value_pair_tokenizer.sv -----
// Testbench for the key/value pair tokenizer: directed and random texts checked against a role predictor.
module tb_key_value_pair_tokenizer;
  import kvpt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [2:0] role;
    logic [7:0] byte_val;
    logic       done;
    logic       dropped;
  } byte_tag_t;

  class role_tracker;
    logic [2:0] phase;
    logic       single_quote;
    byte_tag_t  expected_tags[$];
    int         errors;

    function new();
      phase = PH_BEFORE_KEY;
      single_quote = 1'b0;
      errors = 0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function void take_byte(logic [7:0] c, logic last);
      byte_tag_t t;
      logic      key_held;
      logic      val_open;
      logic [7:0] close_q;
      t.role = ROLE_SKIP;
      t.byte_val = c;
      t.done = 1'b0;
      t.dropped = 1'b0;
      key_held = 1'b0;
      val_open = 1'b0;
      case (phase)
        PH_IN_KEY: begin
          key_held = 1'b1;
          if (c == CH_EQUALS) begin
            t.role = ROLE_EQUALS;
            phase = PH_BEFORE_VALUE;
          end else if (blank(c)) begin
            phase = PH_AFTER_KEY;
          end else begin
            t.role = ROLE_KEY;
          end
        end
        PH_AFTER_KEY: begin
          if (c == CH_EQUALS) begin
            t.role = ROLE_EQUALS;
            phase = PH_BEFORE_VALUE;
            key_held = 1'b1;
          end else if (blank(c)) begin
            key_held = 1'b1;
          end else begin
            t.role = ROLE_HALT;
            phase = PH_HALTED;
            t.dropped = 1'b1;
          end
        end
        PH_BEFORE_VALUE: begin
          if (blank(c)) begin
            key_held = 1'b1;
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            single_quote = (c == CH_SQUOTE);
            phase = PH_IN_QUOTED;
            val_open = 1'b1;
          end else begin
            t.role = ROLE_VALUE;
            phase = PH_IN_PLAIN;
            val_open = 1'b1;
          end
        end
        PH_IN_QUOTED: begin
          close_q = single_quote ? CH_SQUOTE : CH_DQUOTE;
          if (c == close_q) begin
            t.role = ROLE_TERM;
            t.done = 1'b1;
            phase = PH_BEFORE_KEY;
          end else begin
            t.role = ROLE_VALUE;
            val_open = 1'b1;
          end
        end
        PH_IN_PLAIN: begin
          if (blank(c)) begin
            t.role = ROLE_TERM;
            t.done = 1'b1;
            phase = PH_BEFORE_KEY;
          end else begin
            t.role = ROLE_VALUE;
            val_open = 1'b1;
          end
        end
        PH_HALTED: begin
          t.role = ROLE_HALT;
        end
        default: begin
          if (c == CH_EQUALS) begin
            t.role = ROLE_EQUALS;
            phase = PH_BEFORE_VALUE;
            key_held = 1'b1;
          end else if (!blank(c)) begin
            t.role = ROLE_KEY;
            phase = PH_IN_KEY;
            key_held = 1'b1;
          end
        end
      endcase
      if (last) begin
        if (val_open) t.done = 1'b1;
        else if (key_held) t.dropped = 1'b1;
        phase = PH_BEFORE_KEY;
        single_quote = 1'b0;
      end
      expected_tags.push_back(t);
    endfunction

    function void check_tag(logic [2:0] role, logic [7:0] b, logic done, logic dropped);
      byte_tag_t e;
      if (expected_tags.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tag error: beat with nothing expected: role=%0d byte=%h done=%b drop=%b",
                   role, b, done, dropped);
      end else begin
        e = expected_tags.pop_front();
        if (role !== e.role || b !== e.byte_val || done !== e.done || dropped !== e.dropped) begin
          errors++;
          if (errors <= 10)
            $display("tag error: expected role=%0d byte=%h done=%b drop=%b, got role=%0d byte=%h done=%b drop=%b",
                     e.role, e.byte_val, e.done, e.dropped, role, b, done, dropped);
        end
      end
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  kvpt_in_if  in_ch();
  kvpt_out_if out_ch();

  key_value_pair_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  role_tracker tracker;
  logic [7:0]  text_q[$];
  int          sent_cnt;
  int          cycle_cnt;
  bit          hold_req;
  bit          tx_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("key_value_pair_tokenizer: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.take_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready)
        tracker.check_tag(out_ch.role, out_ch.byte_out, out_ch.pair_done, out_ch.pair_dropped);
    end
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] any_char();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] key_char();
    logic [7:0] c;
    c = any_char();
    while (is_blank(c) || c == CH_EQUALS) c = any_char();
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = any_char();
    while (is_blank(c)) c = any_char();
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(logic [7:0] q);
    logic [7:0] c;
    c = ($urandom_range(0, 7) == 0) ? blank_char() : any_char();
    while (c == q) c = any_char();
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0: return blank_char();
      1: return CH_EQUALS;
      2: return CH_DQUOTE;
      3: return CH_SQUOTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void build_text();
    int kind;
    int cut;
    logic [7:0] q;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(noise_char());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
        if ($urandom_range(0, 15) != 0)
          repeat ($urandom_range(1, 5)) text_q.push_back(key_char());
        repeat ($urandom_range(0, 1)) text_q.push_back(blank_char());
        if (kind == 1 && $urandom_range(0, 1) == 1) begin
          text_q.push_back(blank_char());
          text_q.push_back(key_char());
        end
        text_q.push_back(CH_EQUALS);
        repeat ($urandom_range(0, 1)) text_q.push_back(blank_char());
        if ($urandom_range(0, 1) == 1) begin
          q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
          text_q.push_back(q);
          repeat ($urandom_range(0, 6)) text_q.push_back(quoted_char(q));
          text_q.push_back(q);
        end else begin
          repeat ($urandom_range(1, 6)) text_q.push_back(plain_char());
          text_q.push_back(blank_char());
        end
      end
      if (kind <= 2 && $urandom_range(0, 1) == 1) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
  endfunction

  task automatic send_text();
    int gap;
    for (int i = 0; i < text_q.size(); i++) begin
      gap = tx_steady ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= text_q[i];
      in_ch.last_byte <= (i == text_q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      sent_cnt++;
      @(negedge clk);
    end
  endtask

  initial begin
    int gap;
    bit rx_steady;
    rx_steady = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 4);
      end
      repeat (gap) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    tracker = new();
    sent_cnt = 0;
    hold_req = 1'b0;
    tx_steady = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    text_q.delete();
    push_str(" \tk=v\r");
    send_text();
    text_q.delete();
    push_str("=\"a'\"");
    send_text();
    text_q.delete();
    push_str("k xy");
    send_text();
    text_q.delete();
    push_str("a ='");
    send_text();
    text_q.delete();
    push_str("k");
    send_text();
    text_q.delete();
    text_q.push_back(8'h00);
    text_q.push_back(CH_EQUALS);
    text_q.push_back(8'hFF);
    send_text();
    text_q.delete();
    push_str("=\n");
    send_text();

    hold_req = 1'b1;
    while (sent_cnt < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
      if (sent_cnt >= 25 + RANDOM_ITEMS / 2 && sent_cnt < 25 + RANDOM_ITEMS / 2 + 60)
        hold_req = 1'b1;
      build_text();
      send_text();
    end
    in_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("key_value_pair_tokenizer: match");
    end else begin
      $display("key_value_pair_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
